// ===== hw/rtl/cae_pkg.sv =====
// shared constants, tables and codes for the cartesian to azimuth/elevation/range converter
package cae_pkg;

    // default parameter values
    localparam int DEF_CORDIC_STEPS = 16;
    localparam int DEF_COORD_WIDTH  = 32;

    // result field widths
    localparam int RANGE_W = 32;
    localparam int ANGLE_W = 16;

    // apb port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index, taken from the word address bit
    localparam logic REG_FRAME_MODE = 1'b0;

    // vertical convention codes
    localparam logic FRAME_ENU = 1'b0;
    localparam logic FRAME_NED = 1'b1;

    // cordic datapath: 64-bit rotation word, operands normalized into [2^59, 2^60)
    localparam int ROT_W      = 64;
    localparam int NORM_W     = 60;
    localparam int NORM_STEPS = 6;

    // angle accumulator, pi = 2^31
    localparam int Z_W       = 34;
    localparam int FRAC_DROP = 16;
    localparam int RND_W     = Z_W - FRAC_DROP;

    localparam logic signed [Z_W-1:0] Z_PI   = 34'sd2147483648;
    localparam logic signed [Z_W-1:0] Z_HALF = 34'sd32768;

    localparam logic signed [ANGLE_W-1:0] EL_MAX = 16'sd16384;
    localparam logic signed [ANGLE_W-1:0] EL_MIN = -16'sd16384;

    // atan(2^-i), pi = 2^31, rounded to nearest
    localparam int ATAN_N = 32;
    localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

// ===== hw/rtl/cae_square.sv =====
// three-stage sum of squares from split partial products
module cae_square #(
    parameter int CW     = cae_pkg::DEF_COORD_WIDTH,
    parameter int PASS_W = 3 * cae_pkg::DEF_COORD_WIDTH + 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [CW-1:0]       mag_in [3],
    input  logic [PASS_W-1:0]   in_pass,
    output logic                out_valid,
    output logic [2*CW-1:0]     h2_out,
    output logic [2*CW-1:0]     r2_out,
    output logic [PASS_W-1:0]   out_pass
);

    localparam int LO_W = (CW + 1) / 2;
    localparam int HI_W = CW - LO_W;
    localparam int SQ_W = 2 * CW;

    logic                   v1_reg, v2_reg, v3_reg;
    logic [PASS_W-1:0]      p1_reg, p2_reg, p3_reg;
    logic [2*HI_W-1:0]      hh_reg [3];
    logic [HI_W+LO_W-1:0]   hl_reg [3];
    logic [2*LO_W-1:0]      ll_reg [3];
    logic [SQ_W-1:0]        sq_reg [3];
    logic [SQ_W-1:0]        h2_reg, r2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg <= in_pass;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
            // partial products of hi/lo halves
            for (int j = 0; j < 3; j++) begin
                hh_reg[j] <= (2*HI_W)'(mag_in[j][CW-1:LO_W])
                           * (2*HI_W)'(mag_in[j][CW-1:LO_W]);
                hl_reg[j] <= (HI_W+LO_W)'(mag_in[j][CW-1:LO_W])
                           * (HI_W+LO_W)'(mag_in[j][LO_W-1:0]);
                ll_reg[j] <= (2*LO_W)'(mag_in[j][LO_W-1:0])
                           * (2*LO_W)'(mag_in[j][LO_W-1:0]);
            end
            for (int j = 0; j < 3; j++) begin
                sq_reg[j] <= (SQ_W'(hh_reg[j]) << (2 * LO_W))
                           + (SQ_W'(hl_reg[j]) << (LO_W + 1))
                           + SQ_W'(ll_reg[j]);
            end
            h2_reg <= sq_reg[0] + sq_reg[1];
            r2_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    assign out_valid = v3_reg;
    assign h2_out    = h2_reg;
    assign r2_out    = r2_reg;
    assign out_pass  = p3_reg;

endmodule

// ===== hw/rtl/cae_isqrt.sv =====
// two-lane pipelined digit-by-digit integer square root, one result bit per stage
module cae_isqrt #(
    parameter int CW     = cae_pkg::DEF_COORD_WIDTH,
    parameter int PASS_W = 3 * cae_pkg::DEF_COORD_WIDTH + 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2*CW-1:0]     rad_in [2],
    input  logic [PASS_W-1:0]   in_pass,
    output logic                out_valid,
    output logic [CW-1:0]       root_out [2],
    output logic [PASS_W-1:0]   out_pass
);

    localparam int RAD_W = 2 * CW;
    localparam int REM_W = CW + 2;
    localparam int T_W   = CW + 4;

    logic              v_reg [CW];
    logic [PASS_W-1:0] p_reg [CW];

    for (genvar s = 0; s < CW; s++) begin : g_ctl
        logic              v_src;
        logic [PASS_W-1:0] p_src;
        if (s == 0) begin : g_first
            assign v_src = in_valid;
            assign p_src = in_pass;
        end else begin : g_next
            assign v_src = v_reg[s-1];
            assign p_src = p_reg[s-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (en) begin
                v_reg[s] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg[s] <= p_src;
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic [RAD_W-1:0] rad_reg [CW];
        logic [REM_W-1:0] rem_reg [CW];
        logic [CW-1:0]    q_reg   [CW];

        for (genvar s = 0; s < CW; s++) begin : g_stage
            logic [RAD_W-1:0] rad_src;
            logic [REM_W-1:0] rem_src;
            logic [CW-1:0]    q_src;
            logic [T_W-1:0]   trial;
            logic [T_W-1:0]   sub;
            logic [T_W:0]     diff;
            logic             ge;

            if (s == 0) begin : g_first
                assign rad_src = rad_in[l];
                assign rem_src = '0;
                assign q_src   = '0;
            end else begin : g_next
                assign rad_src = rad_reg[s-1];
                assign rem_src = rem_reg[s-1];
                assign q_src   = q_reg[s-1];
            end

            // bring down the next two radicand bits, try subtracting 4q+1
            assign trial = {rem_src, rad_src[RAD_W-1 -: 2]};
            assign sub   = T_W'({q_src, 2'b01});
            assign diff  = {1'b0, trial} - {1'b0, sub};
            assign ge    = ~diff[T_W];

            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[s] <= rad_src << 2;
                    rem_reg[s] <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
                    q_reg[s]   <= {q_src[CW-2:0], ge};
                end
            end
        end

        assign root_out[l] = q_reg[CW-1];
    end

    assign out_valid = v_reg[CW-1];
    assign out_pass  = p_reg[CW-1];

endmodule

// ===== hw/rtl/cae_cordic.sv =====
// two-lane pipelined vectoring cordic atan2 with normalizing front end and rounding
module cae_cordic #(
    parameter int STEPS  = cae_pkg::DEF_CORDIC_STEPS,
    parameter int IN_W   = cae_pkg::DEF_COORD_WIDTH + 1,
    parameter int PASS_W = cae_pkg::RANGE_W
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic signed [IN_W-1:0]           y_in [2],
    input  logic signed [IN_W-1:0]           x_in [2],
    input  logic [PASS_W-1:0]                in_pass,
    output logic                             out_valid,
    output logic signed [cae_pkg::RND_W-1:0] angle_out [2],
    output logic [PASS_W-1:0]                out_pass
);

    localparam int ROT_W  = cae_pkg::ROT_W;
    localparam int NORM_W = cae_pkg::NORM_W;
    localparam int NS     = cae_pkg::NORM_STEPS;
    localparam int Z_W    = cae_pkg::Z_W;
    localparam int RND_W  = cae_pkg::RND_W;
    // entry, normalize, sign fold, micro-rotations, rounding
    localparam int TOT    = NS + STEPS + 3;

    logic              v_reg [TOT];
    logic [PASS_W-1:0] p_reg [TOT];

    for (genvar k = 0; k < TOT; k++) begin : g_ctl
        logic              v_src;
        logic [PASS_W-1:0] p_src;
        if (k == 0) begin : g_first
            assign v_src = in_valid;
            assign p_src = in_pass;
        end else begin : g_next
            assign v_src = v_reg[k-1];
            assign p_src = p_reg[k-1];
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                p_reg[k] <= p_src;
            end
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        logic signed [ROT_W-1:0] nx_reg [NS+1];
        logic signed [ROT_W-1:0] ny_reg [NS+1];
        logic [NORM_W-1:0]       nm_reg [NS+1];
        logic                    zf_reg [TOT-1];
        logic signed [ROT_W-1:0] rx_reg [STEPS+1];
        logic signed [ROT_W-1:0] ry_reg [STEPS+1];
        logic signed [Z_W-1:0]   rz_reg [STEPS+1];
        logic signed [RND_W-1:0] ang_reg;

        // entry: widen, magnitude envelope and zero detect
        logic signed [ROT_W-1:0] xw, yw;
        logic [ROT_W-1:0]        xa, ya, mw;

        assign xw = ROT_W'(x_in[l]);
        assign yw = ROT_W'(y_in[l]);
        assign xa = xw[ROT_W-1] ? -xw : xw;
        assign ya = yw[ROT_W-1] ? -yw : yw;
        assign mw = xa | ya;

        always_ff @(posedge aclk) begin
            if (en) begin
                nx_reg[0] <= xw;
                ny_reg[0] <= yw;
                nm_reg[0] <= mw[NORM_W-1:0];
                zf_reg[0] <= (mw == '0);
            end
        end

        for (genvar k = 1; k < TOT - 1; k++) begin : g_zf
            always_ff @(posedge aclk) begin
                if (en) begin
                    zf_reg[k] <= zf_reg[k-1];
                end
            end
        end

        // binary-search normalization: shift by 32, 16, 8, 4, 2, 1
        for (genvar k = 0; k < NS; k++) begin : g_norm
            localparam int SH = 1 << (NS - 1 - k);
            logic hit;
            assign hit = (nm_reg[k] >> (NORM_W - SH)) == '0;

            always_ff @(posedge aclk) begin
                if (en) begin
                    nx_reg[k+1] <= hit ? (nx_reg[k] <<< SH) : nx_reg[k];
                    ny_reg[k+1] <= hit ? (ny_reg[k] <<< SH) : ny_reg[k];
                    nm_reg[k+1] <= hit ? (nm_reg[k] << SH) : nm_reg[k];
                end
            end
        end

        // left half plane folds over, accumulator starts at pi
        logic neg;
        assign neg = nx_reg[NS][ROT_W-1];

        always_ff @(posedge aclk) begin
            if (en) begin
                rx_reg[0] <= neg ? -nx_reg[NS] : nx_reg[NS];
                ry_reg[0] <= neg ? -ny_reg[NS] : ny_reg[NS];
                rz_reg[0] <= neg ? cae_pkg::Z_PI : '0;
            end
        end

        for (genvar i = 0; i < STEPS; i++) begin : g_rot
            localparam logic signed [Z_W-1:0] A_I = Z_W'(cae_pkg::ATAN_TAB[i]);
            logic signed [ROT_W-1:0] xs, ys;
            assign xs = rx_reg[i] >>> i;
            assign ys = ry_reg[i] >>> i;

            always_ff @(posedge aclk) begin
                if (en) begin
                    if (!ry_reg[i][ROT_W-1]) begin
                        rx_reg[i+1] <= rx_reg[i] + ys;
                        ry_reg[i+1] <= ry_reg[i] - xs;
                        rz_reg[i+1] <= rz_reg[i] + A_I;
                    end else begin
                        rx_reg[i+1] <= rx_reg[i] - ys;
                        ry_reg[i+1] <= ry_reg[i] + xs;
                        rz_reg[i+1] <= rz_reg[i] - A_I;
                    end
                end
            end
        end

        // round half up into the pi = 32768 unit
        logic signed [Z_W-1:0] zr;
        assign zr = rz_reg[STEPS] + cae_pkg::Z_HALF;

        always_ff @(posedge aclk) begin
            if (en) begin
                ang_reg <= zf_reg[TOT-2] ? '0 : zr[Z_W-1:cae_pkg::FRAC_DROP];
            end
        end

        assign angle_out[l] = ang_reg;
    end

    assign out_valid = v_reg[TOT-1];
    assign out_pass  = p_reg[TOT-1];

endmodule

// ===== hw/rtl/cartesian_to_azimuth_elevation_range.sv =====
// top level: stream ports, frame register, pipeline assembly and output skid buffer
//
// converts one local east/north/vertical vector in signed millimetres per transaction into
// slant range (unsigned mm, saturating at 2^32-1), azimuth from north toward east and
// elevation above the horizontal plane (binary angles, pi = 32768, elevation clamped to
// +-16384); the zero vector yields all zeros. frame_mode (apb offset 0, bit 0) selects
// up (0) or down (1) for the vertical input and is sampled as each transaction enters, so it
// should only be written while no transactions are in flight. the block takes one
// transaction every cycle while the output skid register is empty; the pipeline is made of the
// input register, three squaring stages, one square root stage per result bit, the cordic
// (entry, six normalize stages, sign fold, one stage per micro-rotation, rounding) and the
// output register. the whole pipeline holds while the output skid register is occupied,
// so s_tready is a registered signal and a stalled result never blocks the cycle in which
// it is taken
module cartesian_to_azimuth_elevation_range #(
    parameter int CORDIC_STEPS = cae_pkg::DEF_CORDIC_STEPS,
    parameter int COORD_WIDTH  = cae_pkg::DEF_COORD_WIDTH
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    // input stream
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    // east, north, vertical (COORD_WIDTH each), zero padding to bytes
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]             s_tdata,
    // result stream
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // slant_range [31:0], azimuth [47:32], elevation [63:48]
    output logic [cae_pkg::RANGE_W+2*cae_pkg::ANGLE_W-1:0] m_tdata,
    // configuration port
    input  logic                                           psel,
    input  logic                                           penable,
    input  logic                                           pwrite,
    input  logic [cae_pkg::APB_ADDR_W-1:0]                 paddr,
    input  logic [cae_pkg::APB_DATA_W-1:0]                 pwdata,
    output logic [cae_pkg::APB_DATA_W-1:0]                 prdata,
    output logic                                           pready
);

    localparam int CW      = COORD_WIDTH;
    localparam int RANGE_W = cae_pkg::RANGE_W;
    localparam int ANGLE_W = cae_pkg::ANGLE_W;
    localparam int RND_W   = cae_pkg::RND_W;
    localparam int RES_W   = RANGE_W + 2 * ANGLE_W;
    localparam int PASS_W  = 3 * CW + 1;

    // ---------------------------------------------------------------------
    // configuration register
    // ---------------------------------------------------------------------
    logic frame_mode_reg;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_mode_reg <= cae_pkg::FRAME_ENU;
        end else if (cfg_wr && paddr[2] == cae_pkg::REG_FRAME_MODE) begin
            frame_mode_reg <= pwdata[0];
        end
    end

    always_comb begin
        unique case (paddr[2])
            cae_pkg::REG_FRAME_MODE: prdata = cae_pkg::APB_DATA_W'(frame_mode_reg);
            default:                 prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // pipeline advance: everything moves unless the skid register is full
    // ---------------------------------------------------------------------
    logic en;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------------------------------------------------------------
    // input stage: unpack, apply frame convention, magnitudes
    // ---------------------------------------------------------------------
    logic signed [CW-1:0] east_in, north_in, vert_in;
    logic signed [CW:0]   vert_ext, up_in, up_neg;
    logic [CW-1:0]        east_mag, north_mag, up_mag;

    assign east_in  = s_tdata[CW-1:0];
    assign north_in = s_tdata[2*CW-1:CW];
    assign vert_in  = s_tdata[3*CW-1:2*CW];

    // ned vertical points down, flip it to up
    assign vert_ext  = (CW+1)'(vert_in);
    assign up_in     = (frame_mode_reg == cae_pkg::FRAME_NED) ? -vert_ext : vert_ext;
    assign up_neg    = -up_in;
    assign east_mag  = east_in[CW-1] ? CW'(-east_in) : CW'(east_in);
    assign north_mag = north_in[CW-1] ? CW'(-north_in) : CW'(north_in);
    assign up_mag    = up_in[CW] ? up_neg[CW-1:0] : up_in[CW-1:0];

    logic                 in_valid_reg;
    logic signed [CW-1:0] east_reg, north_reg;
    logic signed [CW:0]   up_reg;
    logic [CW-1:0]        mag_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s_tvalid) begin
            east_reg   <= east_in;
            north_reg  <= north_in;
            up_reg     <= up_in;
            mag_reg[0] <= east_mag;
            mag_reg[1] <= north_mag;
            mag_reg[2] <= up_mag;
        end
    end

    // ---------------------------------------------------------------------
    // sums of squares: e^2 + n^2 and e^2 + n^2 + up^2
    // ---------------------------------------------------------------------
    logic              sq_valid;
    logic [2*CW-1:0]   h2, r2;
    logic [PASS_W-1:0] sq_pass;

    cae_square #(
        .CW     (CW),
        .PASS_W (PASS_W)
    ) u_square (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_valid_reg),
        .mag_in    (mag_reg),
        .in_pass   ({up_reg, north_reg, east_reg}),
        .out_valid (sq_valid),
        .h2_out    (h2),
        .r2_out    (r2),
        .out_pass  (sq_pass)
    );

    // ---------------------------------------------------------------------
    // square roots: lane 0 slant range, lane 1 horizontal distance
    // ---------------------------------------------------------------------
    logic              rt_valid;
    logic [2*CW-1:0]   rad [2];
    logic [CW-1:0]     root [2];
    logic [PASS_W-1:0] rt_pass;

    assign rad[0] = r2;
    assign rad[1] = h2;

    cae_isqrt #(
        .CW     (CW),
        .PASS_W (PASS_W)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .rad_in    (rad),
        .in_pass   (sq_pass),
        .out_valid (rt_valid),
        .root_out  (root),
        .out_pass  (rt_pass)
    );

    // range saturates at the top of its field
    logic [CW+RANGE_W-1:0] rng_ext;
    logic [RANGE_W-1:0]    rng_sat;

    assign rng_ext = (CW+RANGE_W)'(root[0]);
    assign rng_sat = (|rng_ext[CW+RANGE_W-1:RANGE_W]) ? '1 : rng_ext[RANGE_W-1:0];

    // ---------------------------------------------------------------------
    // angles: lane 0 azimuth atan2(e, n), lane 1 elevation atan2(up, h)
    // ---------------------------------------------------------------------
    logic signed [CW-1:0] east_p, north_p;
    logic signed [CW:0]   up_p;
    logic signed [CW:0]   cy [2];
    logic signed [CW:0]   cx [2];

    assign east_p  = rt_pass[CW-1:0];
    assign north_p = rt_pass[2*CW-1:CW];
    assign up_p    = rt_pass[3*CW:2*CW];

    assign cy[0] = (CW+1)'(east_p);
    assign cx[0] = (CW+1)'(north_p);
    assign cy[1] = up_p;
    assign cx[1] = {1'b0, root[1]};

    logic                    cd_valid;
    logic signed [RND_W-1:0] angle [2];
    logic [RANGE_W-1:0]      cd_range;

    cae_cordic #(
        .STEPS  (CORDIC_STEPS),
        .IN_W   (CW + 1),
        .PASS_W (RANGE_W)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (rt_valid),
        .y_in      (cy),
        .x_in      (cx),
        .in_pass   (rng_sat),
        .out_valid (cd_valid),
        .angle_out (angle),
        .out_pass  (cd_range)
    );

    // ---------------------------------------------------------------------
    // result formatting: azimuth wraps, elevation clamps to +-pi/2
    // ---------------------------------------------------------------------
    logic signed [RND_W-1:0]   el_hi, el_lo;
    logic signed [ANGLE_W-1:0] el_res, az_res;
    logic [RES_W-1:0]          res;

    assign el_hi  = RND_W'(cae_pkg::EL_MAX);
    assign el_lo  = RND_W'(cae_pkg::EL_MIN);
    assign az_res = angle[0][ANGLE_W-1:0];
    assign el_res = (angle[1] > el_hi) ? cae_pkg::EL_MAX :
                    (angle[1] < el_lo) ? cae_pkg::EL_MIN : angle[1][ANGLE_W-1:0];
    assign res    = {el_res, az_res, cd_range};

    // ---------------------------------------------------------------------
    // output register plus skid register
    // ---------------------------------------------------------------------
    logic             out_valid_reg, out_valid_next;
    logic [RES_W-1:0] out_data_reg, out_data_next;
    logic             skid_valid_next;
    logic [RES_W-1:0] skid_data_reg, skid_data_next;
    logic             out_take;
    logic             arrive;

    assign out_take = out_valid_reg && m_tready;
    assign arrive   = en && cd_valid;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg) begin
            // pipeline is held, drain the skid entry first
            if (out_take) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end else if (arrive) begin
            if (!out_valid_reg || out_take) begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
        end else if (out_take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------------

    // the skid entry is only ever behind a pending output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a transaction with no output pending");

    // the skid entry only fills when the output was stalled
    a_skid_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid register filled while the output was free");

    // zero range means the zero vector, both angles must be zero
    a_zero_vector: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_data_reg[RANGE_W-1:0] == '0)
        |-> (out_data_reg[RES_W-1:RANGE_W] == '0))
        else $error("zero range with nonzero angle");

endmodule

// ===== verif/cartesian_to_azimuth_elevation_range_test.sv =====
// self-checking stream testbench for the cartesian to azimuth/elevation/range converter
module cartesian_to_azimuth_elevation_range_test;
    timeunit 1ns;
    timeprecision 1ps;

    // block configuration, kept at its defaults
    localparam int COORD_W      = 32;
    localparam int STEPS        = 16;
    localparam int S_DATA_W     = ((3*COORD_W+7)/8)*8;
    localparam int M_DATA_W     = cae_pkg::RANGE_W + 2*cae_pkg::ANGLE_W;
    localparam int PIPE_LATENCY = COORD_W + STEPS + 14;

    // stimulus shape
    localparam int MAX_WAIT    = 10;
    localparam int PHASE_N     = 5;
    localparam int PHASE_ITEMS = 225;

    // register map
    localparam logic [cae_pkg::APB_ADDR_W-1:0] FRAME_MODE_ADDR =
        cae_pkg::APB_ADDR_W'(4*cae_pkg::REG_FRAME_MODE);
    localparam logic [cae_pkg::APB_ADDR_W-1:0] UNMAPPED_ADDR   = 3'd4;

    // notable coordinate values
    localparam logic [31:0] COORD_MIN = 32'h8000_0000;
    localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] EXTREME_COORD [4] = '{COORD_MIN, COORD_MAX, 32'd0, 32'hFFFF_FFFF};

    // elevation limit in the pi = 32768 unit
    localparam longint QUARTER_TURN = 16384;

    // micro-rotation angles atan(2^-i), pi = 2^31
    localparam longint ATAN_STEP [STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
    };

    // one result transaction, slant_range in the low bits as on m_tdata
    typedef struct packed {
        logic signed [cae_pkg::ANGLE_W-1:0] elevation;
        logic signed [cae_pkg::ANGLE_W-1:0] azimuth;
        logic [cae_pkg::RANGE_W-1:0]        slant_range;
    } aer_t;

    // one directed vector; typed rows carry their own expected result
    typedef struct packed {
        logic        frame;
        logic        typed;
        logic [31:0] east;
        logic [31:0] north;
        logic [31:0] vertical;
        aer_t        want;
    } probe_t;

    localparam int PROBE_N = 24;
    localparam probe_t PROBES [PROBE_N] = '{
        // zero vector gives all zeros
        '{cae_pkg::FRAME_ENU, 1'b1, 32'd0, 32'd0, 32'd0, '0},
        // the four compass points, due south lands on the azimuth wrap
        '{cae_pkg::FRAME_ENU, 1'b0, 32'd0, 32'd1000, 32'd0, '0},
        '{cae_pkg::FRAME_ENU, 1'b0, 32'd1000, 32'd0, 32'd0, '0},
        '{cae_pkg::FRAME_ENU, 1'b0, 32'd0, -32'sd1000, 32'd0, '0},
        '{cae_pkg::FRAME_ENU, 1'b0, -32'sd1000, 32'd0, 32'd0, '0},
        // either side of due south
        '{cae_pkg::FRAME_ENU, 1'b0, -32'sd1, -32'sd1000000, 32'd0, '0},
        '{cae_pkg::FRAME_ENU, 1'b0, 32'd1, -32'sd1000000, 32'd0, '0},
        // no horizontal part: azimuth zero, elevation at the poles
        '{cae_pkg::FRAME_ENU, 1'b0, 32'd0, 32'd0, 32'd1000, '0},
        '{cae_pkg::FRAME_ENU, 1'b0, 32'd0, 32'd0, -32'sd1000, '0},
        '{cae_pkg::FRAME_ENU, 1'b0, 32'd0, 32'd0, COORD_MIN, '0},
        '{cae_pkg::FRAME_ENU, 1'b0, 32'd0, 32'd0, COORD_MAX, '0},
        // field extremes, largest ranges
        '{cae_pkg::FRAME_ENU, 1'b0, COORD_MIN, COORD_MIN, COORD_MIN, '0},
        '{cae_pkg::FRAME_ENU, 1'b0, COORD_MAX, COORD_MAX, COORD_MAX, '0},
        '{cae_pkg::FRAME_ENU, 1'b0, COORD_MIN, COORD_MAX, COORD_MIN, '0},
        '{cae_pkg::FRAME_ENU, 1'b0, COORD_MAX, COORD_MIN, 32'd0, '0},
        // unit vectors and an exact right triangle
        '{cae_pkg::FRAME_ENU, 1'b0, 32'd1, 32'd1, 32'd1, '0},
        '{cae_pkg::FRAME_ENU, 1'b0, -32'sd1, -32'sd1, -32'sd1, '0},
        '{cae_pkg::FRAME_ENU, 1'b0, 32'd3, 32'd4, 32'd12, '0},
        // tiny horizontal part, elevation pushed toward overshoot
        '{cae_pkg::FRAME_ENU, 1'b0, 32'd1, 32'd0, COORD_MAX, '0},
        // down convention
        '{cae_pkg::FRAME_NED, 1'b1, 32'd0, 32'd0, 32'd0, '0},
        '{cae_pkg::FRAME_NED, 1'b0, 32'd0, 32'd0, 32'd1000, '0},
        '{cae_pkg::FRAME_NED, 1'b0, 32'd0, 32'd0, COORD_MIN, '0},
        '{cae_pkg::FRAME_NED, 1'b0, 32'd1000, 32'd1000, -32'sd1000, '0},
        '{cae_pkg::FRAME_NED, 1'b0, COORD_MAX, COORD_MAX, COORD_MAX, '0}
    };

    // clock, reset and ports; every input starts at a known value
    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    // east [31:0], north [63:32], vertical [95:64]
    logic [S_DATA_W-1:0]            s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    // slant_range [31:0], azimuth [47:32], elevation [63:48]
    logic [M_DATA_W-1:0]            m_tdata;
    logic                           psel     = 1'b0;
    logic                           penable  = 1'b0;
    logic                           pwrite   = 1'b0;
    logic [cae_pkg::APB_ADDR_W-1:0] paddr    = '0;
    logic [cae_pkg::APB_DATA_W-1:0] pwdata   = '0;
    logic [cae_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    // mirror of the frame register and the results still owed by the block
    logic        frame_model = cae_pkg::FRAME_ENU;
    aer_t        aer_pending [$];
    int unsigned error_count = 0;
    bit          tx_burst    = 1'b0;
    bit          rx_burst    = 1'b0;

    cartesian_to_azimuth_elevation_range i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // floor square root of a sum of squares, result below 2^49
    function automatic logic [63:0] isqrt_floor(input logic [127:0] sum);
        logic [63:0] root, cand;
        root = '0;
        for (int b = 48; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (128'(cand) * 128'(cand) <= sum)
                root = cand;
        end
        return root;
    endfunction

    // vectoring cordic atan2(y, x) in the pi = 32768 unit
    function automatic longint cordic_angle(input longint y, input longint x);
        longint unsigned ax, ay, m;
        longint          z, xs, ys;
        int              s;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        m  = (ax > ay) ? ax : ay;
        if (m == 0)
            return 0;
        // normalize so the larger operand lies in [2^59, 2^60)
        s = 0;
        while ((m << s) < (64'd1 << 59))
            s++;
        x = x <<< s;
        y = y <<< s;
        // fold the left half plane over, starting from pi
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 64'sd1 << 31;
        end
        for (int i = 0; i < STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x += ys;
                y -= xs;
                z += ATAN_STEP[i];
            end else begin
                x -= ys;
                y += xs;
                z -= ATAN_STEP[i];
            end
        end
        // round half up to the output unit
        return (z + 32768) >>> 16;
    endfunction

    // range, azimuth and elevation of one vector under the given frame
    function automatic aer_t predict_aer(input logic [31:0] e_raw, n_raw, v_raw,
                                         input logic frame);
        longint          e, n, up, az, el;
        longint unsigned rng, h;
        logic [127:0]    h2, r2;
        aer_t            r;
        e  = longint'($signed(e_raw));
        n  = longint'($signed(n_raw));
        up = longint'($signed(v_raw));
        if (frame == cae_pkg::FRAME_NED)
            up = -up;
        // squares of 32-bit values stay below 2^63
        h2  = 128'($unsigned(e * e)) + 128'($unsigned(n * n));
        r2  = h2 + 128'($unsigned(up * up));
        rng = isqrt_floor(r2);
        h   = isqrt_floor(h2);
        az  = cordic_angle(e, n);
        el  = cordic_angle(up, longint'(h));
        if (el > QUARTER_TURN)
            el = QUARTER_TURN;
        else if (el < -QUARTER_TURN)
            el = -QUARTER_TURN;
        r.slant_range = (rng > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rng[31:0];
        r.azimuth     = az[15:0];
        r.elevation   = el[15:0];
        return r;
    endfunction

    // coordinate mix: full random, near zero, extremes, scaled, zero and powers of two
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 6))
            0, 6: return $urandom;
            1: return 32'($signed($urandom_range(0, 2000)) - 1000);
            2: return EXTREME_COORD[$urandom_range(0, 3)];
            3: return 32'($signed($urandom) >>> $urandom_range(0, 31));
            4: return 32'd0;
            default: return $urandom_range(0, 1) ? (32'd1 << $urandom_range(0, 30))
                                                : -(32'd1 << $urandom_range(0, 30));
        endcase
    endfunction

    // apb write, setup then access phase; mirror updates on the write edge
    task automatic apb_write(input logic [cae_pkg::APB_ADDR_W-1:0] addr,
                             input logic [cae_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // register index comes from the word address bit, others are ignored
        if (addr[2] == cae_pkg::REG_FRAME_MODE)
            frame_model = data[0];
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // apb read of the frame register against the mirror
    task automatic apb_read_frame();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= FRAME_MODE_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== cae_pkg::APB_DATA_W'(frame_model)) begin
            $error("frame_mode: expected %0d, got %0d", frame_model, prdata);
            error_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    // present one vector after a random gap; expectation is queued on acceptance
    task automatic send_vector(input logic [31:0] e, n, v,
                               input logic typed, input aer_t want);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= {v, n, e};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        aer_pending.push_back(typed ? want : predict_aer(e, n, v, frame_model));
        @(negedge aclk);
    endtask

    // hold the input side idle until every owed result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (aer_pending.size() != 0)
            @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    // result side: random stalls between transactions, with bursts of none
    initial begin : result_sink
        int stall;
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && aresetn));
            @(negedge aclk);
        end
    end

    // compare every result transaction with the oldest expectation
    always @(posedge aclk) begin : result_check
        aer_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (aer_pending.size() == 0) begin
                $error("m_tdata: expected nothing, got %h", m_tdata);
                error_count++;
            end else begin
                want = aer_pending.pop_front();
                if (got.slant_range !== want.slant_range) begin
                    $error("slant_range: expected %0d, got %0d",
                           want.slant_range, got.slant_range);
                    error_count++;
                end
                if (got.azimuth !== want.azimuth) begin
                    $error("azimuth: expected %0d, got %0d",
                           $signed(want.azimuth), $signed(got.azimuth));
                    error_count++;
                end
                if (got.elevation !== want.elevation) begin
                    $error("elevation: expected %0d, got %0d",
                           $signed(want.elevation), $signed(got.elevation));
                    error_count++;
                end
            end
        end
    end

    // main sequence: reset, directed vectors, then random phases per frame
    initial begin : stimulus
        logic [cae_pkg::APB_DATA_W-1:0] wdata;
        probe_t                         row;

        // reset held low at the start, released once
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset value, then an explicit write with junk in the upper bits
        apb_read_frame();
        wdata    = $urandom;
        wdata[0] = cae_pkg::FRAME_ENU;
        apb_write(FRAME_MODE_ADDR, wdata);

        // directed table, frame changes only with the pipeline drained
        foreach (PROBES[i]) begin
            row = PROBES[i];
            if (row.frame != frame_model) begin
                wait_for_results();
                wdata    = $urandom;
                wdata[0] = row.frame;
                apb_write(FRAME_MODE_ADDR, wdata);
                apb_read_frame();
            end
            send_vector(row.east, row.north, row.vertical, row.typed, row.want);
        end

        // random phases alternating the frame
        for (int p = 0; p < PHASE_N; p++) begin
            wait_for_results();
            if (p == 2) begin
                // write to an unmapped offset must leave the frame alone
                wdata    = $urandom;
                wdata[0] = !frame_model;
                apb_write(UNMAPPED_ADDR, wdata);
                apb_read_frame();
            end
            wdata    = $urandom;
            wdata[0] = p[0] ? cae_pkg::FRAME_NED : cae_pkg::FRAME_ENU;
            apb_write(FRAME_MODE_ADDR, wdata);
            apb_read_frame();
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // mid-phase hold-off until every result is back
                if (k == PHASE_ITEMS/2)
                    wait_for_results();
                send_vector(rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
            end
        end

        // drain, then allow a pipeline depth for stray transactions
        wait_for_results();
        repeat (PIPE_LATENCY) @(posedge aclk);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial begin : watchdog
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
